@@ rtl/u16nl_pkg.sv @@
`default_nettype none

package u16nl_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned COUNT_W = 17;

    localparam logic [UNIT_W-1:0]  C_NUL          = 16'h0000;
    localparam logic [UNIT_W-1:0]  C_LF           = 16'h000A;
    localparam logic [UNIT_W-1:0]  C_CR           = 16'h000D;
    localparam logic [UNIT_W-1:0]  C_HIGH_FIRST   = 16'hD800;
    localparam logic [UNIT_W-1:0]  C_HIGH_LAST    = 16'hDBFF;
    localparam logic [UNIT_W-1:0]  C_LOW_FIRST    = 16'hDC00;
    localparam logic [UNIT_W-1:0]  C_LOW_LAST     = 16'hDFFF;
    localparam logic [UNIT_W-1:0]  C_TAB          = 16'h0009;
    localparam logic [UNIT_W-1:0]  C_SPACE        = 16'h0020;
    localparam logic [UNIT_W-1:0]  C_NEL          = 16'h0085;
    localparam logic [UNIT_W-1:0]  C_NBSP         = 16'h00A0;
    localparam logic [UNIT_W-1:0]  C_OGHAM        = 16'h1680;
    localparam logic [UNIT_W-1:0]  C_EN_QUAD      = 16'h2000;
    localparam logic [UNIT_W-1:0]  C_HAIR_SPACE   = 16'h200A;
    localparam logic [UNIT_W-1:0]  C_LINE_SEP     = 16'h2028;
    localparam logic [UNIT_W-1:0]  C_PARA_SEP     = 16'h2029;
    localparam logic [UNIT_W-1:0]  C_NNBSP        = 16'h202F;
    localparam logic [UNIT_W-1:0]  C_MMSP         = 16'h205F;
    localparam logic [UNIT_W-1:0]  C_IDEO_SPACE   = 16'h3000;
    localparam logic [UNIT_W-1:0]  C_MAX_UNITS_RST = 16'd4096;
    localparam logic [COUNT_W-1:0] C_COUNT_SAT    = 17'h1FFFF;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_last;
    } t_in_beat;

    typedef struct packed {
        logic [UNIT_W-1:0] out_unit;
        logic              out_valid;
        logic              out_last;
        logic              text_ok;
        logic              already_normalized;
        logic              all_blank;
    } t_out_beat;

    function automatic logic is_high_surr(input logic [UNIT_W-1:0] u);
        return (u >= C_HIGH_FIRST) && (u <= C_HIGH_LAST);
    endfunction

    function automatic logic is_low_surr(input logic [UNIT_W-1:0] u);
        return (u >= C_LOW_FIRST) && (u <= C_LOW_LAST);
    endfunction

    function automatic logic is_blank(input logic [UNIT_W-1:0] u);
        return ((u >= C_TAB) && (u <= C_CR)) || (u == C_SPACE) || (u == C_NEL) ||
               (u == C_NBSP) || (u == C_OGHAM) ||
               ((u >= C_EN_QUAD) && (u <= C_HAIR_SPACE)) ||
               (u == C_LINE_SEP) || (u == C_PARA_SEP) || (u == C_NNBSP) ||
               (u == C_MMSP) || (u == C_IDEO_SPACE);
    endfunction

endpackage

`default_nettype wire

@@ rtl/utf16_check_and_newline_normalize.sv @@
// Streams a UTF-16 text one code unit per clock while unstalled: CR leaves as LF, an
// LF right after a CR leaves with out_valid low, and every other unit passes
// unchanged. The result beat for the unit marked is_last carries text_ok (no NUL,
// surrogates paired, unit count within max_units), already_normalized and all_blank;
// the units leave before the verdict is known, so a consumer discards the text when
// text_ok is low. One unit is taken every cycle unless stalled, through the single
// register-to-register checking step from the input register to the result register.
// Output stall reaches the input stall in the same cycle once both the input register
// and the result register hold a beat. max_units resets to 4096; the user must write it
// through the config channel only while the block is idle; the block does not enforce it.
`default_nettype none

module utf16_check_and_newline_normalize
    import u16nl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_beat          i_in_beat,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_beat              o_out_beat,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [UNIT_W-1:0] i_cfg_data
);

    logic [UNIT_W-1:0] r_max_units;
    logic              stg_valid;
    t_in_beat          stg_beat;
    logic              stg_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= C_MAX_UNITS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_units <= i_cfg_data;
        end
    end

    u16nl_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_beat  (i_in_beat),
        .o_valid (stg_valid),
        .o_beat  (stg_beat),
        .i_take  (stg_take)
    );

    u16nl_proc u_proc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid),
        .i_beat      (stg_beat),
        .o_take      (stg_take),
        .i_max_units (r_max_units),
        .o_valid     (o_out_valid),
        .o_beat      (o_out_beat),
        .i_stall     (i_out_stall)
    );

endmodule

`default_nettype wire

@@ rtl/u16nl_in_stage.sv @@
`default_nettype none

module u16nl_in_stage
    import u16nl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_beat i_beat,
    output logic          o_valid,
    output t_in_beat      o_beat,
    input  wire logic     i_take
);

    logic     r_vld;
    t_in_beat r_beat;
    logic     accept;

    assign o_stall = r_vld && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_vld;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u16nl_proc.sv @@
`default_nettype none

module u16nl_proc
    import u16nl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_in_beat          i_beat,
    output logic                   o_take,
    input  wire logic [UNIT_W-1:0] i_max_units,
    output logic                   o_valid,
    output t_out_beat              o_beat,
    input  wire logic              i_stall
);

    logic               r_vld;
    t_out_beat          r_beat;
    logic               r_high_pending;
    logic               r_prev_was_cr;
    logic [COUNT_W-1:0] r_unit_count;
    logic               r_error_seen;
    logic               r_cr_seen;
    logic               r_nonblank_seen;

    logic               n_high_pending;
    logic               n_prev_was_cr;
    logic [COUNT_W-1:0] n_unit_count;
    logic               n_error_seen;
    logic               n_cr_seen;
    logic               n_nonblank_seen;
    t_out_beat          n_beat;
    logic [UNIT_W-1:0]  u;
    logic               ok;

    assign o_take  = i_valid && (!r_vld || !i_stall);
    assign o_valid = r_vld;
    assign o_beat  = r_beat;
    assign u       = i_beat.code_unit;

    always_comb begin
        n_unit_count = (r_unit_count < C_COUNT_SAT) ? r_unit_count + 1'b1 : r_unit_count;
        n_high_pending = r_high_pending;
        n_error_seen   = r_error_seen;
        if (r_high_pending) begin
            if (!is_low_surr(u)) begin
                n_error_seen = 1'b1;
            end
            n_high_pending = 1'b0;
        end else if (u == C_NUL) begin
            n_error_seen = 1'b1;
        end else if (is_high_surr(u)) begin
            n_high_pending = 1'b1;
        end else if (is_low_surr(u)) begin
            n_error_seen = 1'b1;
        end
        n_nonblank_seen = r_nonblank_seen || !is_blank(u);
        n_cr_seen       = r_cr_seen || (u == C_CR);
        n_prev_was_cr   = (u == C_CR);

        n_beat           = '0;
        n_beat.out_unit  = u;
        n_beat.out_valid = 1'b1;
        n_beat.out_last  = i_beat.is_last;
        if (u == C_CR) begin
            n_beat.out_unit = C_LF;
        end else if ((u == C_LF) && r_prev_was_cr) begin
            n_beat.out_unit  = '0;
            n_beat.out_valid = 1'b0;
        end

        ok = !n_error_seen && !n_high_pending && (n_unit_count <= {1'b0, i_max_units});
        if (i_beat.is_last) begin
            n_beat.text_ok            = ok;
            n_beat.already_normalized = ok && !n_cr_seen;
            n_beat.all_blank          = !n_nonblank_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld           <= 1'b0;
            r_high_pending  <= 1'b0;
            r_prev_was_cr   <= 1'b0;
            r_unit_count    <= '0;
            r_error_seen    <= 1'b0;
            r_cr_seen       <= 1'b0;
            r_nonblank_seen <= 1'b0;
        end else begin
            if (o_take) begin
                r_vld <= 1'b1;
            end else if (!i_stall) begin
                r_vld <= 1'b0;
            end
            if (o_take) begin
                if (i_beat.is_last) begin
                    r_high_pending  <= 1'b0;
                    r_prev_was_cr   <= 1'b0;
                    r_unit_count    <= '0;
                    r_error_seen    <= 1'b0;
                    r_cr_seen       <= 1'b0;
                    r_nonblank_seen <= 1'b0;
                end else begin
                    r_high_pending  <= n_high_pending;
                    r_prev_was_cr   <= n_prev_was_cr;
                    r_unit_count    <= n_unit_count;
                    r_error_seen    <= n_error_seen;
                    r_cr_seen       <= n_cr_seen;
                    r_nonblank_seen <= n_nonblank_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_beat <= n_beat;
        end
    end

    // text state starts over after the last beat
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_beat.is_last) |=> (r_unit_count == '0) && !r_high_pending &&
            !r_error_seen && !r_prev_was_cr)
        else $error("text state not cleared after last beat");

    a_status_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_beat.out_last) |-> (!r_beat.text_ok && !r_beat.already_normalized &&
            !r_beat.all_blank))
        else $error("status flags set on a beat that is not last");

    a_norm_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_beat.already_normalized) |-> r_beat.text_ok)
        else $error("normalized reported on invalid text");

    a_drop_after_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (u == C_LF) && r_prev_was_cr) |=>
            (r_vld && !r_beat.out_valid && (r_beat.out_unit == '0)))
        else $error("lf after cr not dropped");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_beat.is_last && (r_unit_count == C_COUNT_SAT))
            |=> (r_unit_count == C_COUNT_SAT))
        else $error("unit counter wrapped");

endmodule

`default_nettype wire
